// File: rtl/core/cspi_pkg.sv
package cspi_pkg;

    // Loop scaling and field widths
    localparam int FULL_SCALE  = 16320;
    localparam int SPEED_BITS  = 12;
    localparam int FS_W        = $clog2(FULL_SCALE + 1);
    localparam int DOM_W       = 7;
    localparam int CUR_W       = 10;
    localparam int PCNT_W      = 8;
    localparam int LEVEL_W     = 10;
    localparam int RG_W        = 7;
    localparam int STAT_W      = 16;
    localparam int ERR_W       = SPEED_BITS + 1;
    localparam int LVL_SH      = 4;

    // Loop gains and fixed limits
    localparam int P_GAIN_SH   = 8;
    localparam int REGEN_FULL  = 100;
    localparam int DOMAIN_MIN  = 2;
    localparam int REV_PRESSES = 2;

    // Shared multiply / divide unit
    localparam int PROD_W      = CUR_W + FS_W;
    localparam int CNT_W       = $clog2(PROD_W + 1);
    localparam int REGEN_STEPS = DOM_W + RG_W;
    localparam int SOFT_STEPS  = DOM_W + FS_W;
    localparam int SEED_STEPS  = PROD_W;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = CUR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_MAX    = 2'd2;

    // Stream packing
    localparam int IN_THR_BIT  = SPEED_BITS;
    localparam int IN_PAS_BIT  = SPEED_BITS + 1;
    localparam int IN_BTN_BIT  = SPEED_BITS + 2;
    localparam int IN_BRK_BIT  = SPEED_BITS + 3;
    localparam int IN_CUR_LSB  = SPEED_BITS + 4;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 2;

    localparam int OUT_RG_LSB  = LEVEL_W;
    localparam int OUT_ST_LSB  = LEVEL_W + RG_W;
    localparam int OUT_ERR_LSB = OUT_ST_LSB + STAT_W;
    localparam int OUT_ON_BIT  = OUT_ERR_LSB + ERR_W;
    localparam int OUT_REV_BIT = OUT_ON_BIT + 1;
    localparam int M_TDATA_W   = OUT_REV_BIT + 1;

    // Status bit positions
    localparam int ST_ON         = 0;
    localparam int ST_HARD_UNDER = 1;
    localparam int ST_HARD_OVER  = 2;
    localparam int ST_I_HIGH     = 4;
    localparam int ST_I_LOW      = 5;
    localparam int ST_SUM_LOW    = 6;
    localparam int ST_SUM_HIGH   = 7;
    localparam int ST_SLOW_ZONE  = 8;
    localparam int ST_SLOW_APPLY = 9;
    localparam int ST_FAST_ZONE  = 12;
    localparam int ST_FAST_APPLY = 13;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_UPDATE,
        OP_STOP,
        OP_ENGAGE
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_POST,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        JOB_SEED,
        JOB_REGEN,
        JOB_SOFT_MIN,
        JOB_SOFT_MAX
    } t_job;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [CUR_W-1:0]  divisor;
        logic [CNT_W-1:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: rtl/core/cspi_div.sv
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned so that only the requested number of steps is run.
module cspi_div
    import cspi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CUR_W-1:0] r_rem;
    logic [CUR_W-1:0] r_dsr;
    logic [PROD_W-1:0] r_quo;

    logic [CUR_W:0]   trial;
    logic [CUR_W:0]   diff;
    logic             fits;

    always_comb begin
        trial = {r_rem, r_quo[PROD_W-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = (trial >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dsr <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[CUR_W-1:0] : trial[CUR_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: rtl/core/cruise_speed_pi_controller_core.sv
// Path from input transaction to output register: a stop, update or unseeded engage runs
// S_EXEC then S_DONE; a plain tick S_EXEC, S_TICK, S_DONE. A seeded engage (24-step divide)
// and a tick with a soft clamp (21-step divide) go through S_MUL, S_DSTART, S_DIV, S_POST to
// S_DONE; a regen divide (14 steps) runs that sequence before S_TICK. Throughput: one item
// at a time; tready returns the cycle after the result is loaded, later while the output is stalled.
// Reset: synchronous active-low i_rst_n clears all cruise state and loads config defaults.
module cruise_speed_pi_controller_core
    import cspi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: speed_erps[11:0], throttle_active[12], pas_active[13],
    //        button_level[14], brake_active[15], battery_current[25:16], zero fill
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: throttle_level[9:0], regen_percent[16:10], status_bits[32:17],
    //        speed_error[45:33], cruise_on[46], reverse_on[47]
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int ACC_W = ERR_W + P_GAIN_SH + 1;
    localparam logic [FS_W-1:0]         FS_U   = FS_W'(FULL_SCALE);
    localparam logic signed [ACC_W-1:0] FS_ACC = ACC_W'(FULL_SCALE);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DOM_W-1:0] r_dom;
    logic [CUR_W-1:0] r_coff;
    logic [CUR_W-1:0] r_cmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dom  <= DOM_W'(DOMAIN_MIN);
            r_coff <= '0;
            r_cmax <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DOMAIN:     r_dom  <= i_cfg_wdata[DOM_W-1:0];
                CFG_CUR_OFFSET: r_coff <= i_cfg_wdata[CUR_W-1:0];
                CFG_CUR_MAX:    r_cmax <= i_cfg_wdata[CUR_W-1:0];
                default:        ;
            endcase
        end
    end

    // Domain below the minimum acts as the minimum; a zero span acts as one.
    logic [DOM_W-1:0] eff_d;
    logic [DOM_W-1:0] half;
    logic [CUR_W-1:0] span;
    logic signed [ERR_W-1:0] d_s;
    logic signed [ERR_W-1:0] half_s;

    always_comb begin
        eff_d  = (r_dom < DOM_W'(DOMAIN_MIN)) ? DOM_W'(DOMAIN_MIN) : r_dom;
        half   = eff_d >> 1;
        span   = (r_cmax == '0) ? CUR_W'(1) : r_cmax;
        d_s    = $signed(ERR_W'(eff_d));
        half_s = $signed(ERR_W'(half));
    end

    // ------------------------------------------------------------------
    // Sequencer and item registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    // captured input transaction
    t_op                   r_op;
    logic [SPEED_BITS-1:0] r_speed;
    logic                  r_thr;
    logic                  r_pas;
    logic                  r_btn;
    logic                  r_brk;
    logic [CUR_W-1:0]      r_cur;

    // cruise state
    logic [SPEED_BITS-1:0] r_set,     n_set;
    logic [FS_W-1:0]       r_integ,   n_integ;
    logic                  r_bprev,   n_bprev;
    logic [PCNT_W-1:0]     r_pcnt,    n_pcnt;
    logic                  r_brkprev, n_brkprev;
    logic                  r_rev,     n_rev;

    // working registers of the current item
    logic signed [ERR_W-1:0] r_delta,  n_delta;
    logic [LEVEL_W-1:0]      r_level,  n_level;
    logic [RG_W-1:0]         r_rg,     n_rg;
    logic [STAT_W-1:0]       r_status, n_status;
    logic signed [ERR_W-1:0] r_err,    n_err;
    logic [FS_W-1:0]         r_sum,    n_sum;
    t_job                    r_job,    n_job;
    logic [CUR_W-1:0]        r_mul_a,  n_mul_a;
    logic [FS_W-1:0]         r_mul_b,  n_mul_b;
    logic [CUR_W-1:0]        r_dsr,    n_dsr;
    logic [PROD_W-1:0]       r_dvd,    n_dvd;

    // output register
    logic                 r_m_valid, n_m_valid;
    logic [M_TDATA_W-1:0] r_m_data,  n_m_data;

    logic s_accept;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // ------------------------------------------------------------------
    // Shared multiply / divide
    // ------------------------------------------------------------------
    t_div_req div_req;
    t_div_rsp div_rsp;
    logic [CNT_W-1:0]  job_steps;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] q;
    logic [FS_W-1:0]   q_sat;
    logic [FS_W-1:0]   q_inv;

    // Each job runs only as many divide steps as its dividend can have bits.
    always_comb begin
        unique case (r_job)
            JOB_SEED:     job_steps = CNT_W'(SEED_STEPS);
            JOB_REGEN:    job_steps = CNT_W'(REGEN_STEPS);
            JOB_SOFT_MIN: job_steps = CNT_W'(SOFT_STEPS);
            JOB_SOFT_MAX: job_steps = CNT_W'(SOFT_STEPS);
        endcase
    end

    always_comb begin
        prod             = PROD_W'(r_mul_a) * PROD_W'(r_mul_b);
        div_req.start    = (r_state == S_DSTART);
        div_req.dividend = r_dvd;
        div_req.divisor  = r_dsr;
        div_req.steps    = job_steps;
        q                = div_rsp.quotient;
        // saturate a quotient at full scale, or take it off full scale floored at zero
        q_sat            = (q > PROD_W'(FULL_SCALE)) ? FS_U : q[FS_W-1:0];
        q_inv            = (q > PROD_W'(FULL_SCALE)) ? '0 : FS_U - q[FS_W-1:0];
    end

    cspi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // PI step arithmetic, from the registered error and integrator
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] dx;
    logic signed [ACC_W-1:0] i_raw;
    logic signed [ACC_W-1:0] sum_raw;
    logic [FS_W-1:0]         i_lim;
    logic [FS_W-1:0]         sum_lim;
    logic                    i_hi, i_lo, s_lo, s_hi;
    logic signed [ERR_W:0]   extra;

    always_comb begin
        dx    = ACC_W'(r_delta);
        // integrator gain of ten as two shifted terms
        i_raw = $signed(ACC_W'(r_integ)) + (dx <<< 3) + (dx <<< 1);
        i_hi  = (i_raw > FS_ACC);
        i_lo  = (i_raw < 0);
        if (i_hi) begin
            i_lim = FS_U;
        end else if (i_lo) begin
            i_lim = '0;
        end else begin
            i_lim = i_raw[FS_W-1:0];
        end
        sum_raw = (dx <<< P_GAIN_SH) + $signed(ACC_W'(i_lim));
        s_lo    = (sum_raw < 0);
        s_hi    = (sum_raw > FS_ACC);
        if (s_lo) begin
            sum_lim = '0;
        end else if (s_hi) begin
            sum_lim = FS_U;
        end else begin
            sum_lim = sum_raw[FS_W-1:0];
        end
        // overspeed beyond set speed plus domain, for regen
        extra = $signed({2'b00, r_speed}) - $signed({2'b00, r_set})
              - $signed((ERR_W+1)'(eff_d));
    end

    // ------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------
    always_comb begin
        logic              pressed;
        logic [PCNT_W-1:0] pc_inc;
        logic              rev_next;
        logic              do_engage;
        logic signed [ERR_W-1:0] soft_mag;

        pressed   = !r_bprev && r_btn;
        pc_inc    = r_pcnt + PCNT_W'(pressed);
        rev_next  = r_rev;
        do_engage = 1'b0;
        soft_mag  = '0;

        n_state   = r_state;
        n_set     = r_set;
        n_integ   = r_integ;
        n_bprev   = r_bprev;
        n_pcnt    = r_pcnt;
        n_brkprev = r_brkprev;
        n_rev     = r_rev;
        n_delta   = r_delta;
        n_level   = r_level;
        n_rg      = r_rg;
        n_status  = r_status;
        n_err     = r_err;
        n_sum     = r_sum;
        n_job     = r_job;
        n_mul_a   = r_mul_a;
        n_mul_b   = r_mul_b;
        n_dsr     = r_dsr;
        n_dvd     = r_dvd;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_data  = r_m_data;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                // non-tick items report zeros in the loop fields
                n_level  = '0;
                n_rg     = '0;
                n_status = '0;
                n_err    = '0;
                n_delta  = $signed({1'b0, r_set}) - $signed({1'b0, r_speed});
                n_state  = S_DONE;
                unique case (r_op)
                    OP_TICK: begin
                        n_state = S_TICK;
                        if (r_set != '0 && !r_thr && !r_pas && extra >= 0) begin
                            if (extra > $signed((ERR_W+1)'(eff_d))) begin
                                n_rg = RG_W'(REGEN_FULL);
                            end else begin
                                // regen = extra * 100 / domain
                                n_mul_a = CUR_W'(extra[DOM_W-1:0]);
                                n_mul_b = FS_W'(REGEN_FULL);
                                n_dsr   = CUR_W'(eff_d);
                                n_job   = JOB_REGEN;
                                n_state = S_MUL;
                            end
                        end
                    end
                    OP_UPDATE: begin
                        n_bprev = r_btn;
                        if (r_brk) begin
                            // brake stops cruise; a fresh brake restarts the press count
                            n_set     = '0;
                            n_integ   = '0;
                            n_pcnt    = r_brkprev ? pc_inc : '0;
                            n_brkprev = 1'b1;
                            if (r_speed == '0) begin
                                n_rev = 1'b0;
                            end
                        end else begin
                            n_pcnt = pc_inc;
                            // double press after a brake at standstill, with throttle
                            if (r_speed == '0 && r_brkprev && !r_btn &&
                                pc_inc == PCNT_W'(REV_PRESSES) && r_thr) begin
                                rev_next = 1'b1;
                            end
                            n_rev     = rev_next;
                            n_brkprev = 1'b0;
                            do_engage = pressed && !rev_next;
                        end
                    end
                    OP_STOP: begin
                        n_set   = '0;
                        n_integ = '0;
                    end
                    OP_ENGAGE: begin
                        do_engage = 1'b1;
                    end
                endcase

                if (do_engage) begin
                    n_set = r_speed;
                    if (r_speed == '0 || r_cur < r_coff) begin
                        n_integ = '0;
                        n_state = S_DONE;
                    end else begin
                        // seed = (current - offset) * full scale / span
                        n_mul_a = r_cur - r_coff;
                        n_mul_b = FS_U;
                        n_dsr   = span;
                        n_job   = JOB_SEED;
                        n_state = S_MUL;
                    end
                end
            end

            S_TICK: begin
                n_state  = S_DONE;
                n_status = '0;
                n_err    = '0;
                n_level  = '0;
                if (r_set == '0) begin
                    n_integ = '0;
                end else begin
                    n_status[ST_ON] = 1'b1;
                    n_err           = r_delta;
                    if (r_delta > d_s) begin
                        n_status[ST_HARD_UNDER] = 1'b1;
                        n_integ = FS_U;
                        n_level = LEVEL_W'(FS_U >> LVL_SH);
                    end else if (r_delta < -d_s) begin
                        n_status[ST_HARD_OVER] = 1'b1;
                        n_integ = '0;
                    end else begin
                        n_status[ST_I_HIGH]   = i_hi;
                        n_status[ST_I_LOW]    = i_lo;
                        n_status[ST_SUM_LOW]  = s_lo;
                        n_status[ST_SUM_HIGH] = s_hi;
                        n_integ = i_lim;
                        n_sum   = sum_lim;
                        n_level = LEVEL_W'(sum_lim >> LVL_SH);
                        n_mul_b = FS_U;
                        n_dsr   = CUR_W'(half);
                        if (r_delta > half_s) begin
                            // slow side: ramp up a minimum throttle
                            n_status[ST_SLOW_ZONE] = 1'b1;
                            soft_mag = r_delta - half_s;
                            n_mul_a  = soft_mag[CUR_W-1:0];
                            n_job    = JOB_SOFT_MIN;
                            n_state  = S_MUL;
                        end else if (r_delta < -half_s) begin
                            // fast side: ramp down a maximum throttle
                            n_status[ST_FAST_ZONE] = 1'b1;
                            soft_mag = -(r_delta + half_s);
                            n_mul_a  = soft_mag[CUR_W-1:0];
                            n_job    = JOB_SOFT_MAX;
                            n_state  = S_MUL;
                        end
                    end
                end
            end

            S_MUL: begin
                // left-align the product so the divider runs only the job's steps
                n_dvd   = prod << (CNT_W'(PROD_W) - job_steps);
                n_state = S_DSTART;
            end

            S_DSTART: begin
                n_state = S_DIV;
            end

            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_POST;
                end
            end

            S_POST: begin
                n_state = S_DONE;
                unique case (r_job)
                    JOB_SEED: begin
                        n_integ = q_sat;
                    end
                    JOB_REGEN: begin
                        n_rg    = q[RG_W-1:0];
                        n_state = S_TICK;
                    end
                    JOB_SOFT_MIN: begin
                        if (r_sum < q_sat) begin
                            n_status[ST_SLOW_APPLY] = 1'b1;
                            n_integ = q_sat;
                            n_sum   = q_sat;
                            n_level = LEVEL_W'(q_sat >> LVL_SH);
                        end
                    end
                    JOB_SOFT_MAX: begin
                        if (r_sum > q_inv) begin
                            n_status[ST_FAST_APPLY] = 1'b1;
                            n_integ = q_inv;
                            n_sum   = q_inv;
                            n_level = LEVEL_W'(q_inv >> LVL_SH);
                        end
                    end
                endcase
            end

            S_DONE: begin
                // hold until the output register is free, then hand the result over
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {r_rev, (r_set != '0), r_err, r_status, r_rg, r_level};
                    n_state   = S_IDLE;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_set     <= '0;
            r_integ   <= '0;
            r_bprev   <= 1'b0;
            r_pcnt    <= '0;
            r_brkprev <= 1'b0;
            r_rev     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_set     <= n_set;
            r_integ   <= n_integ;
            r_bprev   <= n_bprev;
            r_pcnt    <= n_pcnt;
            r_brkprev <= n_brkprev;
            r_rev     <= n_rev;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op    <= t_op'(s_axis_tuser);
            r_speed <= s_axis_tdata[SPEED_BITS-1:0];
            r_thr   <= s_axis_tdata[IN_THR_BIT];
            r_pas   <= s_axis_tdata[IN_PAS_BIT];
            r_btn   <= s_axis_tdata[IN_BTN_BIT];
            r_brk   <= s_axis_tdata[IN_BRK_BIT];
            r_cur   <= s_axis_tdata[IN_CUR_LSB +: CUR_W];
        end
        r_delta  <= n_delta;
        r_level  <= n_level;
        r_rg     <= n_rg;
        r_status <= n_status;
        r_err    <= n_err;
        r_sum    <= n_sum;
        r_job    <= n_job;
        r_mul_a  <= n_mul_a;
        r_mul_b  <= n_mul_b;
        r_dsr    <= n_dsr;
        r_dvd    <= n_dvd;
        r_m_data <= n_m_data;
    end

endmodule

// File: rtl/core/cspi_chk.sv
module cspi_chk
    import cspi_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // the block works on one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // loop status only while cruise is engaged
    a_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_ST_LSB + ST_ON] |-> m_axis_tdata[OUT_ON_BIT])
        else $error("loop status without cruise engaged");

    // regen only comes from a tick with cruise engaged
    a_regen_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[OUT_RG_LSB +: RG_W] != '0)
        |-> m_axis_tdata[OUT_ON_BIT] && m_axis_tdata[OUT_ST_LSB + ST_ON])
        else $error("regen demand without an engaged tick");

    // no loop activity reported: error and throttle stay zero
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_ST_LSB + ST_ON]
        |-> (m_axis_tdata[OUT_ERR_LSB +: ERR_W] == '0) && (m_axis_tdata[LEVEL_W-1:0] == '0))
        else $error("error or throttle without loop activity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

endmodule

bind cruise_speed_pi_controller_core cspi_chk u_cspi_chk (.*);

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import cspi_pkg::*;

    // Integral gain of the loop (error * 10 per tick)
    localparam int I_GAIN     = 10;
    localparam int DRAIN_WAIT = 60;
    localparam int DRAIN_MAX  = 5000;

    // One input transaction, field by field
    typedef struct {
        t_op        op;
        logic [11:0] speed;
        logic       thr;
        logic       pas;
        logic       btn;
        logic       brk;
        logic [9:0] cur;
    } t_cmd;

    // One output transaction; packed so that it lines up with m_axis_tdata
    typedef struct packed {
        logic              rev;
        logic              on;
        logic signed [12:0] err;
        logic [15:0]       status;
        logic [6:0]        regen;
        logic [9:0]        level;
    } t_loop_out;

    typedef struct {
        t_cmd      c;
        bit        typed;
        t_loop_out exp;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    cruise_speed_pi_controller_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the configuration registers
    int cf_domain  = 2;
    int cf_cur_off = 0;
    int cf_cur_max = 1023;

    // Mirror of the controller state
    logic [11:0] pr_set_speed = '0;
    int          pr_integ     = 0;
    bit          pr_btn_prev  = 1'b0;
    logic [7:0]  pr_presses   = '0;
    bit          pr_brk_prev  = 1'b0;
    bit          pr_reverse   = 1'b0;

    t_loop_out loop_outputs_q[$];
    t_dir_row  dir_rows[$];
    int        fail_count = 0;
    bit        idle_en    = 1'b1;
    int        stall_left = 0;

    // Set the cruise speed and seed the integrator from battery current
    function automatic void seed_engage(logic [11:0] spd, logic [9:0] cur);
        int span;
        int seed;
        span = (cf_cur_max == 0) ? 1 : cf_cur_max;
        pr_set_speed = spd;
        if (spd == 0 || int'(cur) < cf_cur_off) begin
            pr_integ = 0;
        end else begin
            seed = ((int'(cur) - cf_cur_off) * FULL_SCALE) / span;
            if (seed > FULL_SCALE) seed = FULL_SCALE;
            pr_integ = seed;
        end
    endfunction

    // Advance the mirrored state by one transaction and return the output it causes
    function automatic t_loop_out cruise_step(t_cmd c);
        t_loop_out o;
        int dom, half, delta, sum, extra, lim, mag;
        bit pressed;
        o = '0;
        dom = (cf_domain < DOMAIN_MIN) ? DOMAIN_MIN : cf_domain;
        half = dom / 2;
        case (c.op)
            OP_TICK: begin
                // regen first: it looks at the set speed only
                if (pr_set_speed != 0 && !c.thr && !c.pas) begin
                    extra = int'(c.speed) - (int'(pr_set_speed) + dom);
                    if (extra > dom) o.regen = 7'(REGEN_FULL);
                    else if (extra >= 0) o.regen = 7'((extra * REGEN_FULL) / dom);
                end
                if (pr_set_speed == 0) begin
                    pr_integ = 0;
                end else begin
                    o.status[ST_ON] = 1'b1;
                    delta = int'(pr_set_speed) - int'(c.speed);
                    o.err = 13'(delta);
                    if (delta > dom) begin
                        o.status[ST_HARD_UNDER] = 1'b1;
                        pr_integ = FULL_SCALE;
                        o.level = 10'(FULL_SCALE >> LVL_SH);
                    end else if (delta < -dom) begin
                        o.status[ST_HARD_OVER] = 1'b1;
                        pr_integ = 0;
                    end else begin
                        pr_integ += delta * I_GAIN;
                        if (pr_integ > FULL_SCALE) begin
                            pr_integ = FULL_SCALE;
                            o.status[ST_I_HIGH] = 1'b1;
                        end
                        if (pr_integ < 0) begin
                            pr_integ = 0;
                            o.status[ST_I_LOW] = 1'b1;
                        end
                        sum = delta * (1 << P_GAIN_SH) + pr_integ;
                        if (sum < 0) begin
                            sum = 0;
                            o.status[ST_SUM_LOW] = 1'b1;
                        end
                        if (sum > FULL_SCALE) begin
                            sum = FULL_SCALE;
                            o.status[ST_SUM_HIGH] = 1'b1;
                        end
                        // ramped floor when well below set speed
                        if (delta > half) begin
                            lim = ((delta - half) * FULL_SCALE) / half;
                            if (lim > FULL_SCALE) lim = FULL_SCALE;
                            o.status[ST_SLOW_ZONE] = 1'b1;
                            if (sum < lim) begin
                                pr_integ = lim;
                                sum = lim;
                                o.status[ST_SLOW_APPLY] = 1'b1;
                            end
                        end
                        // ramped ceiling when well above set speed
                        if (delta < -half) begin
                            mag = -(delta + half);
                            lim = FULL_SCALE - (mag * FULL_SCALE) / half;
                            if (lim < 0) lim = 0;
                            o.status[ST_FAST_ZONE] = 1'b1;
                            if (sum > lim) begin
                                pr_integ = lim;
                                sum = lim;
                                o.status[ST_FAST_APPLY] = 1'b1;
                            end
                        end
                        o.level = 10'(sum >> LVL_SH);
                    end
                end
            end
            OP_UPDATE: begin
                pressed = 1'b0;
                if (!pr_btn_prev && c.btn) begin
                    pressed = 1'b1;
                    pr_btn_prev = 1'b1;
                    pr_presses = pr_presses + 8'd1;
                end
                if (pr_btn_prev && !c.btn) pr_btn_prev = 1'b0;
                if (c.brk) begin
                    pr_set_speed = '0;
                    pr_integ = 0;
                    if (!pr_brk_prev) pr_presses = '0;
                    pr_brk_prev = 1'b1;
                    if (c.speed == 0 && pr_reverse) pr_reverse = 1'b0;
                end else begin
                    if (c.speed == 0 && pr_brk_prev && !pr_btn_prev
                            && pr_presses == REV_PRESSES && c.thr)
                        pr_reverse = 1'b1;
                    if (pr_reverse) pressed = 1'b0;
                    pr_brk_prev = 1'b0;
                    if (pressed) seed_engage(c.speed, c.cur);
                end
            end
            OP_STOP: begin
                pr_set_speed = '0;
                pr_integ = 0;
            end
            default: seed_engage(c.speed, c.cur);
        endcase
        o.on = (pr_set_speed != 0);
        o.rev = pr_reverse;
        return o;
    endfunction

    function automatic t_cmd mk_cmd(t_op op, int spd, bit thr, bit pas, bit btn, bit brk,
                                    int cur);
        t_cmd c;
        c.op = op;
        c.speed = 12'(spd);
        c.thr = thr;
        c.pas = pas;
        c.btn = btn;
        c.brk = brk;
        c.cur = 10'(cur);
        return c;
    endfunction

    function automatic void add_row(t_op op, int spd, bit thr, bit pas, bit btn, bit brk,
                                    int cur, bit typed, int lvl, int rg, int st, int er,
                                    bit on, bit rev);
        t_dir_row r;
        r.c = mk_cmd(op, spd, thr, pas, btn, brk, cur);
        r.typed = typed;
        r.exp.level = 10'(lvl);
        r.exp.regen = 7'(rg);
        r.exp.status = 16'(st);
        r.exp.err = 13'(er);
        r.exp.on = on;
        r.exp.rev = rev;
        dir_rows.push_back(r);
    endfunction

    // Random item: mostly speeds around the set speed, so the loop leaves the hard clamps
    function automatic t_cmd rand_cmd();
        t_cmd c;
        int r, mode, base, spd, cur, dom;
        dom = (cf_domain < DOMAIN_MIN) ? DOMAIN_MIN : cf_domain;
        r = $urandom_range(0, 99);
        if (r < 45) c.op = OP_TICK;
        else if (r < 75) c.op = OP_UPDATE;
        else if (r < 82) c.op = OP_STOP;
        else c.op = OP_ENGAGE;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            spd = 0;
        end else if (mode < 3) begin
            spd = $urandom_range(0, 4095);
        end else begin
            base = (pr_set_speed != 0) ? int'(pr_set_speed) : $urandom_range(1, 4095);
            spd = base + $urandom_range(0, 4 * dom + 6) - (2 * dom + 3);
            if (spd < 0) spd = 0;
            if (spd > 4095) spd = 4095;
        end
        if ($urandom_range(0, 1)) begin
            cur = $urandom_range(0, 1023);
        end else begin
            cur = cf_cur_off + $urandom_range(0, 40) - 8;
            if (cur < 0) cur = 0;
            if (cur > 1023) cur = 1023;
        end
        c.speed = 12'(spd);
        c.cur = 10'(cur);
        c.thr = ($urandom_range(0, 3) == 0);
        c.pas = ($urandom_range(0, 4) == 0);
        c.btn = 1'($urandom_range(0, 1));
        c.brk = ($urandom_range(0, 5) == 0);
        return c;
    endfunction

    // Call right after a rising edge; leaves tvalid high after the transaction
    task automatic send_cmd(t_cmd c, bit typed, t_loop_out typed_exp);
        t_loop_out predicted;
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= {6'd0, c.cur, c.brk, c.btn, c.pas, c.thr, c.speed};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = cruise_step(c);
        loop_outputs_q.push_back(typed ? typed_exp : predicted);
    endtask

    task automatic send_rand(t_cmd c);
        send_cmd(c, 1'b0, '0);
    endtask

    // Hold off until every output is back and the block has settled
    task automatic drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (loop_outputs_q.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_cfg(int dom, int off, int cmax);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_DOMAIN;
        i_cfg_wdata <= CFG_DATA_W'(dom);
        cf_domain = dom & 'h7F;
        @(posedge i_clk);
        i_cfg_idx <= CFG_CUR_OFFSET;
        i_cfg_wdata <= CFG_DATA_W'(off);
        cf_cur_off = off;
        @(posedge i_clk);
        i_cfg_idx <= CFG_CUR_MAX;
        i_cfg_wdata <= CFG_DATA_W'(cmax);
        cf_cur_max = cmax;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Brake, the given number of presses under the brake, then release at standstill, mostly with throttle
    task automatic standstill_double_press(int presses);
        send_rand(mk_cmd(OP_UPDATE, $urandom_range(0, 1) ? 0 : $urandom_range(0, 4095),
                         0, 1'($urandom_range(0, 1)), 0, 1, $urandom_range(0, 1023)));
        repeat (presses) begin
            send_rand(mk_cmd(OP_UPDATE, $urandom_range(0, 4095), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1, 1, $urandom_range(0, 1023)));
            send_rand(mk_cmd(OP_UPDATE, $urandom_range(0, 4095), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 0, 1, $urandom_range(0, 1023)));
        end
        send_rand(mk_cmd(OP_UPDATE, 0, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                         0, 0, $urandom_range(0, 1023)));
    endtask

    // Compare one field; log and count a mismatch
    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Output side: check each transaction and stall in random bursts
    always @(posedge i_clk) begin
        t_loop_out want;
        t_loop_out got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_loop_out'(m_axis_tdata);
            if (loop_outputs_q.size() == 0) begin
                $display("%0t: unexpected output transaction, expected none actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = loop_outputs_q.pop_front();
                check_field("throttle_level", want.level, got.level);
                check_field("regen_percent", want.regen, got.regen);
                check_field("status_bits", want.status, got.status);
                check_field("speed_error", $signed(want.err), $signed(got.err));
                check_field("cruise_on", want.on, got.on);
                check_field("reverse_on", want.rev, got.rev);
            end
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 19);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Hard stop if the run hangs
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int ph, n;
        int dom, off, cmax;
        // Directed rows at reset configuration: domain 2, offset 0, span 1023.
        // Cruise off after reset: every field zero.
        add_row(OP_TICK,    50,   0, 0, 0, 0, 0,    1, 0, 0, 0, 0, 0, 0);
        add_row(OP_STOP,    0,    0, 0, 0, 0, 0,    1, 0, 0, 0, 0, 0, 0);
        // engage at zero speed leaves cruise off
        add_row(OP_ENGAGE,  0,    0, 0, 0, 0, 500,  1, 0, 0, 0, 0, 0, 0);
        // double press under the brake at standstill, then throttle: reverse on
        add_row(OP_UPDATE,  0,    0, 0, 0, 1, 0,    1, 0, 0, 0, 0, 0, 0);
        add_row(OP_UPDATE,  0,    0, 0, 1, 1, 0,    1, 0, 0, 0, 0, 0, 0);
        add_row(OP_UPDATE,  0,    0, 0, 0, 1, 0,    1, 0, 0, 0, 0, 0, 0);
        add_row(OP_UPDATE,  0,    0, 0, 1, 1, 0,    1, 0, 0, 0, 0, 0, 0);
        add_row(OP_UPDATE,  0,    0, 0, 0, 1, 0,    1, 0, 0, 0, 0, 0, 0);
        add_row(OP_UPDATE,  0,    1, 0, 0, 0, 0,    1, 0, 0, 0, 0, 0, 1);
        // a press in reverse must not engage
        add_row(OP_UPDATE,  300,  0, 0, 1, 0, 700,  0, 0, 0, 0, 0, 0, 0);
        // brake at standstill drops reverse
        add_row(OP_UPDATE,  0,    0, 0, 0, 1, 0,    1, 0, 0, 0, 0, 0, 0);
        // full-scale seed, then extremes of the speed field
        add_row(OP_ENGAGE,  4095, 0, 0, 0, 0, 1023, 1, 0, 0, 0, 0, 1, 0);
        add_row(OP_TICK,    4095, 0, 0, 0, 0, 0,    1, 1020, 0, 1, 0, 1, 0);
        add_row(OP_TICK,    0,    0, 0, 0, 0, 0,    1, 1020, 0, 3, 4095, 1, 0);
        add_row(OP_ENGAGE,  100,  0, 0, 0, 0, 0,    0, 0, 0, 0, 0, 0, 0);
        add_row(OP_TICK,    4095, 0, 0, 0, 0, 0,    1, 0, 100, 5, -3995, 1, 0);
        add_row(OP_TICK,    4095, 1, 1, 0, 0, 0,    0, 0, 0, 0, 0, 0, 0);
        // inside the window: integrator and sum limits, soft ramps
        add_row(OP_TICK,    101,  0, 0, 0, 0, 0,    0, 0, 0, 0, 0, 0, 0);
        add_row(OP_TICK,    102,  0, 0, 0, 0, 0,    0, 0, 0, 0, 0, 0, 0);
        add_row(OP_TICK,    98,   0, 0, 0, 0, 0,    0, 0, 0, 0, 0, 0, 0);
        add_row(OP_TICK,    99,   0, 1, 0, 0, 0,    0, 0, 0, 0, 0, 0, 0);
        // button edge engages from an update
        add_row(OP_UPDATE,  200,  0, 0, 1, 0, 1023, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_UPDATE,  200,  0, 0, 0, 0, 1023, 0, 0, 0, 0, 0, 0, 0);
        add_row(OP_STOP,    0,    0, 0, 0, 0, 0,    1, 0, 0, 0, 0, 0, 0);
        add_row(OP_TICK,    7,    0, 0, 0, 0, 0,    1, 0, 0, 0, 0, 0, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].exp);
        drain();

        // Configuration phases: extremes first, then random settings
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin dom = 0;   off = 0;    cmax = 0;    end
                1: begin dom = 127; off = 1023; cmax = 1023; end
                2: begin dom = 1;   off = 512;  cmax = 1;    end
                3: begin dom = 64;  off = 100;  cmax = 700;  end
                default: begin
                    dom = $urandom_range(2, 127);
                    off = $urandom_range(0, 1023);
                    cmax = $urandom_range(1, 1023);
                end
            endcase
            idle_en = (ph != 5);
            write_cfg(dom, off, cmax);
            // run the press counter through its wrap back to two
            if (ph == 3) standstill_double_press(258);
            n = 0;
            while (n < 240) begin
                if ($urandom_range(0, 49) == 0) begin
                    standstill_double_press(2);
                    n += 6;
                end else begin
                    send_rand(rand_cmd());
                    n++;
                end
            end
            drain();
        end

        if (loop_outputs_q.size() != 0) begin
            $display("%0t: outputs missing, expected %0d more actual 0",
                     $time, loop_outputs_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
